### design/rc4_pkg.sv
package rc4_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD_TABLE = 2'd0,
        KIND_LOAD_KEY   = 2'd1,
        KIND_SCHEDULE   = 2'd2,
        KIND_ENCRYPT    = 2'd3
    } rc4_kind_t;

    typedef struct packed {
        rc4_kind_t   kind;
        logic [7:0]  index;
        logic [7:0]  data_value;
    } rc4_in_t;

    typedef struct packed {
        logic [7:0]  out_value;
        logic        is_cipher;
    } rc4_out_t;

    // result handed from the sequencer to the output buffer
    typedef struct packed {
        logic        valid;
        rc4_out_t    item;
    } rc4_res_t;

    localparam int KEY_DEPTH = 256;
    localparam int KLEN_W    = 9;

endpackage

### design/rc4_core.sv
module rc4_core import rc4_pkg::*; #(
    parameter int TABLE_SIZE = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rc4_in_t           s_data,
    input  logic [KLEN_W-1:0] key_length,
    input  logic              buf_ready,
    output rc4_res_t          res
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int SW    = IDX_W + 2;
    localparam logic [SW-1:0]    N_VAL  = SW'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] N_LAST = IDX_W'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_EN_RD_J,
        ST_EN_WR_I,
        ST_EN_WR_J
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] gen_i_reg;
    logic [IDX_W-1:0] gen_j_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [7:0]       kidx_reg;
    logic [7:0]       si_reg;
    logic [7:0]       sj_reg;
    logic [7:0]       data_reg;
    logic             fwd_reg;
    logic             fwd_sj_reg;
    logic             fwd_si_reg;

    logic [7:0]       perm_mem [TABLE_SIZE];
    logic [7:0]       key_mem  [KEY_DEPTH];
    logic [7:0]       p_rdata_reg;
    logic [7:0]       k_rdata_reg;

    logic [IDX_W-1:0] mod_rom [256];

    logic             acc;
    logic             p_we;
    logic [IDX_W-1:0] p_waddr;
    logic [7:0]       p_wdata;
    logic [IDX_W-1:0] p_raddr;
    logic [7:0]       k_raddr;
    logic             k_we;

    logic [7:0]       klast;
    logic [7:0]       kidx_next;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] gen_i_inc;
    logic [7:0]       si_val;
    logic [IDX_W-1:0] ks_j_new;
    logic [IDX_W-1:0] en_j_new;
    logic [IDX_W-1:0] t_val;
    logic [7:0]       ks_byte;
    logic             table_in_range;

    // byte mod TABLE_SIZE, built at elaboration
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign mod_rom[g] = IDX_W'(g % TABLE_SIZE);
    end

    // sum of up to three reduced terms back into [0, TABLE_SIZE)
    function automatic logic [IDX_W-1:0] red2(input logic [SW-1:0] s);
        logic [SW-1:0] a;
        a = (s >= N_VAL) ? s - N_VAL : s;
        a = (a >= N_VAL) ? a - N_VAL : a;
        return a[IDX_W-1:0];
    endfunction

    assign s_ready = (state_reg == ST_IDLE) && buf_ready;
    assign acc     = s_valid && s_ready;

    assign table_in_range = ({1'b0, s_data.index} < 9'(TABLE_SIZE));

    // last key position; zero acts as one, above 256 acts as 256
    assign klast = key_length[8] ? 8'hFF :
                   ((key_length[7:0] == 8'd0) ? 8'd0 : key_length[7:0] - 8'd1);
    assign kidx_next = (kidx_reg == klast) ? 8'd0 : kidx_reg + 8'd1;
    assign i_next    = i_reg + IDX_W'(1);
    assign gen_i_inc = (gen_i_reg == N_LAST) ? '0 : gen_i_reg + IDX_W'(1);

    // S[i] may still sit in si_reg when i+1 hit the entry being written
    assign si_val   = fwd_reg ? si_reg : p_rdata_reg;
    assign ks_j_new = red2({2'b00, j_reg} + {2'b00, mod_rom[si_val]}
                           + {2'b00, mod_rom[k_rdata_reg]});
    assign en_j_new = red2({2'b00, gen_j_reg} + {2'b00, mod_rom[si_val]});
    assign t_val    = red2({2'b00, mod_rom[si_reg]} + {2'b00, mod_rom[p_rdata_reg]});
    assign ks_byte  = fwd_sj_reg ? sj_reg : (fwd_si_reg ? si_reg : p_rdata_reg);

    always_comb begin
        p_we    = 1'b0;
        p_waddr = i_reg;
        p_wdata = p_rdata_reg;
        p_raddr = '0;
        k_raddr = kidx_reg;
        k_we    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                p_raddr = (s_data.kind == KIND_SCHEDULE) ? '0 : gen_i_inc;
                k_raddr = 8'd0;
                if (acc && s_data.kind == KIND_LOAD_TABLE && table_in_range) begin
                    p_we    = 1'b1;
                    p_waddr = s_data.index[IDX_W-1:0];
                    p_wdata = s_data.data_value;
                end
                k_we = acc && (s_data.kind == KIND_LOAD_KEY);
            end
            ST_KS_RD_J: begin
                p_raddr = ks_j_new;
            end
            ST_EN_RD_J: begin
                p_raddr = en_j_new;
            end
            ST_KS_WR_I: begin
                p_we = 1'b1;
            end
            ST_EN_WR_I: begin
                p_we    = 1'b1;
                p_raddr = t_val;
            end
            ST_KS_WR_J: begin
                p_we    = 1'b1;
                p_waddr = j_reg;
                p_wdata = si_reg;
                p_raddr = i_next;
                k_raddr = kidx_next;
            end
            ST_EN_WR_J: begin
                p_we    = 1'b1;
                p_waddr = j_reg;
                p_wdata = si_reg;
            end
            default: begin
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            perm_mem[p_waddr] <= p_wdata;
        end
        p_rdata_reg <= perm_mem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (k_we) begin
            key_mem[s_data.index] <= s_data.data_value;
        end
        k_rdata_reg <= key_mem[k_raddr];
    end

    always_comb begin
        res.valid          = 1'b0;
        res.item.out_value = 8'd0;
        res.item.is_cipher = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                res.valid = acc && (s_data.kind == KIND_LOAD_TABLE ||
                                    s_data.kind == KIND_LOAD_KEY);
            end
            ST_KS_WR_J: begin
                res.valid = (i_reg == N_LAST);
            end
            ST_EN_WR_J: begin
                res.valid          = 1'b1;
                res.item.out_value = data_reg ^ ks_byte;
                res.item.is_cipher = 1'b1;
            end
            default: begin
                res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gen_i_reg <= '0;
            gen_j_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (acc && s_data.kind == KIND_SCHEDULE) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        kidx_reg  <= 8'd0;
                        fwd_reg   <= 1'b0;
                        state_reg <= ST_KS_RD_J;
                    end else if (acc && s_data.kind == KIND_ENCRYPT) begin
                        i_reg     <= gen_i_inc;
                        data_reg  <= s_data.data_value;
                        fwd_reg   <= 1'b0;
                        state_reg <= ST_EN_RD_J;
                    end
                end
                ST_KS_RD_J: begin
                    si_reg    <= si_val;
                    j_reg     <= ks_j_new;
                    state_reg <= ST_KS_WR_I;
                end
                ST_KS_WR_I: begin
                    state_reg <= ST_KS_WR_J;
                end
                ST_KS_WR_J: begin
                    if (i_reg == N_LAST) begin
                        gen_i_reg <= '0;
                        gen_j_reg <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        i_reg     <= i_next;
                        kidx_reg  <= kidx_next;
                        fwd_reg   <= (i_next == j_reg);
                        state_reg <= ST_KS_RD_J;
                    end
                end
                ST_EN_RD_J: begin
                    si_reg    <= si_val;
                    j_reg     <= en_j_new;
                    state_reg <= ST_EN_WR_I;
                end
                ST_EN_WR_I: begin
                    // keystream read overlaps both swap writes
                    sj_reg     <= p_rdata_reg;
                    fwd_sj_reg <= (t_val == i_reg);
                    fwd_si_reg <= (t_val == j_reg);
                    state_reg  <= ST_EN_WR_J;
                end
                ST_EN_WR_J: begin
                    gen_i_reg <= i_reg;
                    gen_j_reg <= j_reg;
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_enc_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_data.kind == KIND_ENCRYPT) |-> ##3 (res.valid && res.item.is_cipher))
        else $error("encrypt item did not produce a cipher byte on time");

    a_load_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && (s_data.kind == KIND_LOAD_TABLE || s_data.kind == KIND_LOAD_KEY))
        |-> (res.valid && !res.item.is_cipher))
        else $error("load item not acknowledged");

    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KS_RD_J || state_reg == ST_EN_RD_J) |-> !p_we)
        else $error("table write during j lookup");

    a_ks_clears_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KS_WR_J && res.valid)
        |=> (gen_i_reg == '0 && gen_j_reg == '0 && state_reg == ST_IDLE))
        else $error("pointers not cleared after key scheduling");

endmodule

### design/rc4_result_buf.sv
module rc4_result_buf import rc4_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  rc4_res_t res,
    output logic     buf_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output rc4_out_t m_data
);

    logic     pend_valid_reg;
    rc4_out_t pend_reg;
    logic     out_valid_reg;
    rc4_out_t out_reg;
    logic     out_free;

    assign out_free  = !out_valid_reg || m_ready;
    assign buf_ready = !pend_valid_reg || out_free;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_free) begin
                if (pend_valid_reg) begin
                    out_reg        <= pend_reg;
                    out_valid_reg  <= 1'b1;
                    pend_valid_reg <= res.valid;
                    pend_reg       <= res.item;
                end else begin
                    out_valid_reg <= res.valid;
                    out_reg       <= res.item;
                end
            end else if (!pend_valid_reg && res.valid) begin
                // output stalled: park the item
                pend_valid_reg <= 1'b1;
                pend_reg       <= res.item;
            end
        end
    end

endmodule

### design/rc4_stream_cipher.sv
// Loads (table entry, key byte): one item per cycle while the output buffer has
// room. Encrypt takes no new item until the last is through; the swap needs two
// writes on the table's single write port after a dependent S[i], S[j] read.
// Key scheduling reads S[j], writes S[i], writes S[j] for every table entry.
// Synchronous active-low reset clears the sequencer, i, j and the output side,
// and sets key_length to 1; the table and key memories are not cleared.
module rc4_stream_cipher import rc4_pkg::*; #(
    parameter int TABLE_SIZE = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rc4_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rc4_out_t          m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KLEN_W-1:0] cfg_data
);

    logic [KLEN_W-1:0] key_length_reg;
    rc4_res_t          res;
    logic              buf_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= KLEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            key_length_reg <= cfg_data;
        end
    end

    rc4_core #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .key_length (key_length_reg),
        .buf_ready  (buf_ready),
        .res        (res)
    );

    rc4_result_buf u_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .buf_ready (buf_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### tb/sv/tb_rc4_stream_cipher.sv
module tb_rc4_stream_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4_pkg::*;

    localparam int TABLE_N = 256;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    rc4_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    rc4_out_t          m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [KLEN_W-1:0] cfg_data;

    // shadow of the cipher state
    logic [7:0]        perm_s [TABLE_N];
    logic [7:0]        key_b  [KEY_DEPTH];
    int unsigned       gen_i;
    int unsigned       gen_j;
    logic [KLEN_W-1:0] key_len;

    rc4_out_t          reply_q [$];

    int err_cnt   = 0;
    int n_items   = 0;
    int n_cipher  = 0;
    int n_sched   = 0;
    int n_cfg     = 0;
    int n_replies = 0;
    bit in_burst  = 1'b0;
    bit out_burst = 1'b0;

    rc4_stream_cipher #(
        .TABLE_SIZE(TABLE_N)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic rc4_in_t mk_item(rc4_kind_t k, logic [7:0] idx, logic [7:0] d);
        rc4_in_t it;
        it.kind       = k;
        it.index      = idx;
        it.data_value = d;
        return it;
    endfunction

    function automatic void swap_perm(int unsigned a, int unsigned b);
        logic [7:0] tmp;
        tmp       = perm_s[a];
        perm_s[a] = perm_s[b];
        perm_s[b] = tmp;
    endfunction

    // advances the shadow state by one item and returns its reply
    function automatic rc4_out_t step_cipher(rc4_in_t it);
        rc4_out_t    r;
        int unsigned klen;
        int unsigned j;
        int unsigned t;
        r = '0;
        case (it.kind)
            KIND_LOAD_TABLE: begin
                if (it.index < TABLE_N)
                    perm_s[it.index] = it.data_value;
            end
            KIND_LOAD_KEY: begin
                key_b[it.index] = it.data_value;
            end
            KIND_SCHEDULE: begin
                klen = 32'(key_len);
                if (klen == 0)
                    klen = 1;
                if (klen > 256)
                    klen = 256;
                j = 0;
                for (int i = 0; i < TABLE_N; i++) begin
                    j = (j + perm_s[i] + key_b[i % klen]) % TABLE_N;
                    swap_perm(i, j);
                end
                gen_i = 0;
                gen_j = 0;
            end
            default: begin
                gen_i = (gen_i + 1) % TABLE_N;
                gen_j = (gen_j + perm_s[gen_i]) % TABLE_N;
                swap_perm(gen_i, gen_j);
                t = (perm_s[gen_i] + perm_s[gen_j]) % TABLE_N;
                r.out_value = it.data_value ^ perm_s[t];
                r.is_cipher = 1'b1;
            end
        endcase
        return r;
    endfunction

    // valid stays up after acceptance; the next call either reuses it or drops it
    task automatic send_item(rc4_in_t it);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        reply_q.insert(reply_q.size(), step_cipher(it));
        n_items++;
        case (it.kind)
            KIND_ENCRYPT:  n_cipher++;
            KIND_SCHEDULE: n_sched++;
            default: ;
        endcase
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reply_q.size() != 0);
    endtask

    task automatic set_key_length(logic [KLEN_W-1:0] v);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        key_len = v;
        n_cfg++;
    endtask

    function automatic logic [KLEN_W-1:0] pick_key_length();
        case ($urandom_range(0, 5))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'd511;
            4:       return KLEN_W'($urandom_range(2, 255));
            default: return KLEN_W'($urandom_range(257, 510));
        endcase
    endfunction

    // every table entry and key byte gets written before anything reads them
    task automatic test_preload();
        for (int i = 0; i < TABLE_N; i++)
            send_item(mk_item(KIND_LOAD_TABLE, 8'(i), 8'($urandom_range(0, 255))));
        for (int i = 0; i < KEY_DEPTH; i++)
            send_item(mk_item(KIND_LOAD_KEY, 8'(i), 8'($urandom_range(0, 255))));
    endtask

    // i and j must start at zero straight out of reset
    task automatic test_encrypt_from_reset();
        send_item(mk_item(KIND_ENCRYPT, 8'h00, 8'h00));
        send_item(mk_item(KIND_ENCRYPT, 8'hFF, 8'hFF));
    endtask

    task automatic test_field_extremes();
        send_item(mk_item(KIND_LOAD_TABLE, 8'h00, 8'hFF));
        send_item(mk_item(KIND_LOAD_TABLE, 8'hFF, 8'h00));
        send_item(mk_item(KIND_LOAD_KEY, 8'h00, 8'h00));
        send_item(mk_item(KIND_LOAD_KEY, 8'hFF, 8'hFF));
    endtask

    task automatic test_schedule_default_length();
        send_item(mk_item(KIND_SCHEDULE, 8'h00, 8'h00));
        send_item(mk_item(KIND_ENCRYPT, 8'h00, 8'h00));
        send_item(mk_item(KIND_ENCRYPT, 8'h00, 8'hFF));
    endtask

    // zero acts as one, anything past 256 acts as 256
    task automatic test_key_length_edges();
        logic [KLEN_W-1:0] lens [4];
        lens = '{9'd0, 9'd256, 9'd511, 9'd257};
        foreach (lens[n]) begin
            set_key_length(lens[n]);
            send_item(mk_item(KIND_SCHEDULE, 8'hFF, 8'hFF));
            send_item(mk_item(KIND_ENCRYPT, 8'h00, 8'hA5));
        end
    endtask

    task automatic test_random_sessions(int count);
        int stop_at;
        int nk;
        int n_enc;
        stop_at = n_items + count;
        while (n_items < stop_at) begin
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
                // rekey, schedule, then a run of bytes
                if ($urandom_range(0, 3) == 0) begin
                    nk = $urandom_range(1, 4);
                    repeat (nk)
                        send_item(mk_item(KIND_LOAD_TABLE, 8'($urandom_range(0, 255)),
                                          8'($urandom_range(0, 255))));
                end
                nk = $urandom_range(0, 6);
                repeat (nk)
                    send_item(mk_item(KIND_LOAD_KEY, 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))));
                if ($urandom_range(0, 2) == 0)
                    set_key_length(pick_key_length());
                send_item(mk_item(KIND_SCHEDULE, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255))));
                n_enc = $urandom_range(4, 30);
                repeat (n_enc)
                    send_item(mk_item(KIND_ENCRYPT, 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))));
            end else begin
                nk = $urandom_range(5, 20);
                repeat (nk)
                    send_item(mk_item(rc4_kind_t'($urandom_range(0, 3)),
                                      8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))));
            end
        end
        in_burst  = 1'b0;
        out_burst = 1'b0;
    endtask

    // result side: random stall before each item
    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = out_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin : check_reply
        rc4_out_t want;
        if (aresetn && m_valid && m_ready) begin
            n_replies++;
            if (reply_q.size() == 0) begin
                $error("unexpected result: out_value=%02h is_cipher=%0b",
                       m_data.out_value, m_data.is_cipher);
                err_cnt++;
            end else begin
                want = reply_q.pop_front();
                if (m_data.out_value !== want.out_value) begin
                    $error("out_value mismatch: expected %02h, actual %02h",
                           want.out_value, m_data.out_value);
                    err_cnt++;
                end
                if (m_data.is_cipher !== want.is_cipher) begin
                    $error("is_cipher mismatch: expected %0b, actual %0b",
                           want.is_cipher, m_data.is_cipher);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int guard;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        gen_i   = 0;
        gen_j   = 0;
        key_len = 9'd1;
        foreach (perm_s[n])
            perm_s[n] = '0;
        foreach (key_b[n])
            key_b[n] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_preload();
        test_encrypt_from_reset();
        test_field_extremes();
        test_schedule_default_length();
        test_key_length_edges();
        test_random_sessions(620);

        s_valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (reply_q.size() != 0 && guard < 20000);
        repeat (8) @(posedge aclk);
        if (reply_q.size() != 0) begin
            $error("%0d results never arrived", reply_q.size());
            err_cnt++;
        end

        $display("Sent %0d items: %0d byte encryptions, %0d key schedules, %0d key_length writes",
                 n_items, n_cipher, n_sched, n_cfg);
        $display("Checked %0d results against the shadow cipher state", n_replies);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
